// ===== rtl/sps_pkg.sv =====
package sps_pkg;

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  localparam int unsigned SelW   = 2;
  localparam int unsigned ValueW = 32;

  typedef struct packed {
    action_e                   action;
    logic [SelW-1:0]           stack_sel;
    logic signed [ValueW-1:0]  push_value;
  } sps_in_t;

  typedef struct packed {
    logic signed [ValueW-1:0]  top_value;
    logic                      stk_empty;
    status_e                   status;
  } sps_out_t;

  // Commands from the sequencer to the datapath, one per step of an item.
  typedef struct packed {
    logic load;     // capture the accepted item
    logic link_rd;  // read the link of the node that the operation takes
    logic update;   // write pointers, free list and node memories
    logic val_rd;   // read the value of the new top node
  } sps_cmd_t;

endpackage

// ===== rtl/shared_pool_multi_stack.sv =====
// Channel   Ports                    Beat accepted when
// -------   ----------------------   ---------------------------------------
// command   start, busy, item_i      rising edge with start high, busy low
// result    done_o, result_o         rising edge ending the cycle done_o is high
//
// After its accepting edge, every item goes through link read, pointer update,
// value read and result cycle, in that order. The two node memories, each read
// once per item with registered read data, set this schedule. busy is low in
// the result cycle, so the next item can be accepted while the current result
// is on the ports. Reset clears all top pointers, the free list head and the
// fresh node counter; node memories need no clearing. The receiver cannot
// stall: a result is shown for one cycle only.
module shared_pool_multi_stack
  import sps_pkg::*;
#(
  parameter int unsigned POOL_SIZE  = 256,
  parameter int unsigned NUM_STACKS = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  sps_in_t  item_i,
  output logic     done_o,
  output sps_out_t result_o
);

  sps_cmd_t cmd;

  // The sequencer steps each item through its fixed schedule.
  sps_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd),
    .done_o (done_o)
  );

  // The datapath owns the node pool, the stack top pointers, the free list
  // head and the bump counter that hands out nodes never used before.
  sps_dp #(
    .POOL_SIZE  (POOL_SIZE),
    .NUM_STACKS (NUM_STACKS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .item_i   (item_i),
    .result_o (result_o)
  );

  // An accepted item produces its result after the link, update and value steps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##4 done_o)
    else $error("result not delivered four cycles after accept");

  // Once accepted, an item keeps the block busy on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("block not busy after accepting an item");

  // A pop that found the stack empty must report the stack as empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.status == STAT_EMPTY)) |-> result_o.stk_empty)
    else $error("empty-pop status with non-empty stack");

  // An empty stack always shows a zero top value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.stk_empty) |-> (result_o.top_value == '0))
    else $error("empty stack shows a nonzero top value");

endmodule

// ===== rtl/sps_ctrl.sv =====
module sps_ctrl
  import sps_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  output sps_cmd_t cmd_o,
  output logic     done_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LINK = 5'b00010,
    S_UPD  = 5'b00100,
    S_VAL  = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign busy   = (state_q != S_IDLE) && (state_q != S_OUT);
  assign accept = start && !busy;
  assign done_o = (state_q == S_OUT);

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.load    = accept;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_LINK;
      end
      S_LINK: begin
        cmd_o.link_rd = 1'b1;
        state_d       = S_UPD;
      end
      S_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = S_VAL;
      end
      S_VAL: begin
        cmd_o.val_rd = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        state_d = accept ? S_LINK : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/sps_dp.sv =====
module sps_dp
  import sps_pkg::*;
#(
  parameter int unsigned POOL_SIZE  = 256,
  parameter int unsigned NUM_STACKS = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  sps_cmd_t cmd_i,
  input  sps_in_t  item_i,
  output sps_out_t result_o
);

  localparam int unsigned PtrW  = $clog2(POOL_SIZE + 1);
  localparam int unsigned AddrW = $clog2(POOL_SIZE);
  localparam int unsigned StkW  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam logic [PtrW-1:0] PtrNull = PtrW'(POOL_SIZE);

  sps_in_t           item_q;
  logic [PtrW-1:0]   top_q [NUM_STACKS];
  logic [PtrW-1:0]   free_head_q;
  logic [PtrW-1:0]   fresh_q;
  logic [PtrW-1:0]   link_rd_q;
  logic [ValueW-1:0] val_rd_q;
  logic              top_ok_q;
  status_e           status_q;

  logic [PtrW-1:0]   link_mem [POOL_SIZE];
  logic [ValueW-1:0] value_mem [POOL_SIZE];

  logic              sel_ok;
  logic [StkW-1:0]   stk_idx;
  logic [PtrW-1:0]   cur_top;
  logic              cur_top_ok;
  logic              free_ok;
  logic              fresh_ok;
  logic              push_ok;
  logic [PtrW-1:0]   push_node;
  logic              is_push;
  logic              do_push;
  logic              do_pop;
  logic [AddrW-1:0]  link_raddr;
  logic [AddrW-1:0]  node_waddr;
  logic [AddrW-1:0]  val_raddr;
  logic [PtrW-1:0]   link_wdata;

  assign sel_ok     = (32'(item_q.stack_sel) < 32'(NUM_STACKS));
  assign stk_idx    = StkW'(item_q.stack_sel);
  assign cur_top    = top_q[stk_idx];
  assign cur_top_ok = sel_ok && (cur_top < PtrNull);
  assign free_ok    = (free_head_q < PtrNull);
  assign fresh_ok   = (fresh_q < PtrNull);
  assign push_ok    = free_ok || fresh_ok;
  assign push_node  = free_ok ? free_head_q : fresh_q;
  assign is_push    = (item_q.action == ACT_PUSH);
  assign do_push    = cmd_i.update && sel_ok && is_push && push_ok;
  assign do_pop     = cmd_i.update && !is_push && cur_top_ok;

  // A push needs the link of the free-list head, a pop the link of the top node.
  always_comb begin
    link_raddr = '0;
    if (is_push) begin
      if (free_ok) link_raddr = free_head_q[AddrW-1:0];
    end else if (cur_top_ok) begin
      link_raddr = cur_top[AddrW-1:0];
    end
  end

  assign node_waddr = is_push ? push_node[AddrW-1:0] : cur_top[AddrW-1:0];
  assign link_wdata = is_push ? cur_top : free_head_q;
  assign val_raddr  = cur_top_ok ? cur_top[AddrW-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= item_i;
    if (do_push || do_pop) link_mem[node_waddr] <= link_wdata;
    if (cmd_i.link_rd) link_rd_q <= link_mem[link_raddr];
    if (do_push) value_mem[node_waddr] <= item_q.push_value;
    if (cmd_i.val_rd) begin
      val_rd_q <= value_mem[val_raddr];
      top_ok_q <= cur_top_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned s = 0; s < NUM_STACKS; s++) begin
        top_q[s] <= PtrNull;
      end
      free_head_q <= PtrNull;
      fresh_q     <= '0;
      status_q    <= STAT_OK;
    end else begin
      if (cmd_i.update) begin
        if (sel_ok && is_push && !push_ok) begin
          status_q <= STAT_FULL;
        end else if (sel_ok && !is_push && !cur_top_ok) begin
          status_q <= STAT_EMPTY;
        end else begin
          status_q <= STAT_OK;
        end
      end
      if (do_push) begin
        top_q[stk_idx] <= push_node;
        if (free_ok) begin
          free_head_q <= link_rd_q;
        end else begin
          fresh_q <= fresh_q + PtrW'(1);
        end
      end
      if (do_pop) begin
        top_q[stk_idx] <= link_rd_q;
        free_head_q    <= cur_top;
      end
    end
  end

  assign result_o.top_value = top_ok_q ? val_rd_q : '0;
  assign result_o.stk_empty = !top_ok_q;
  assign result_o.status    = status_q;

endmodule
